FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under the async active-low reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication under the async active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/ssmd_pkg.sv
// ----------------------------------------------------------------------------
// ssmd_pkg
// Constants, command codes, segment tables and shared types for the
// scrolling seven-segment display driver.
// ----------------------------------------------------------------------------
package ssmd_pkg;

  localparam int BufLen     = 16;
  localparam int DigitCount = 4;
  localparam int SlotTicks  = 100;

  localparam int BufAw    = $clog2(BufLen);
  localparam int DigW     = $clog2(DigitCount);
  localparam int SlotW    = 7;
  localparam int SegW     = 7;
  localparam int BrtW     = 7;
  localparam int WinSpan  = BufLen - DigitCount;

  localparam int KindW    = 4;
  localparam int PosW     = 4;
  localparam int CharW    = 8;
  localparam int DvalW    = 8;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;

  // command codes
  localparam logic [KindW-1:0] KIND_TICK     = 4'd0;
  localparam logic [KindW-1:0] KIND_ROT_TICK = 4'd1;
  localparam logic [KindW-1:0] KIND_WR_CHAR  = 4'd2;
  localparam logic [KindW-1:0] KIND_WR_DIGIT = 4'd3;
  localparam logic [KindW-1:0] KIND_CLEAR    = 4'd4;
  localparam logic [KindW-1:0] KIND_START    = 4'd5;
  localparam logic [KindW-1:0] KIND_LEFT     = 4'd6;
  localparam logic [KindW-1:0] KIND_RIGHT    = 4'd7;
  localparam logic [KindW-1:0] KIND_SET_WIN  = 4'd8;
  localparam logic [KindW-1:0] KIND_HL_SOFT  = 4'd9;
  localparam logic [KindW-1:0] KIND_HL_HARD  = 4'd10;
  localparam logic [KindW-1:0] KIND_HL_OFF   = 4'd11;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_NOMINAL  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_ROT = 1'd1;

  localparam logic [BrtW-1:0] HighDuty     = 7'd100;
  localparam logic [BrtW-1:0] LowDuty      = 7'd10;
  localparam logic [BrtW-1:0] MinNominal   = 7'd10;
  localparam logic [BrtW-1:0] MaxNominal   = 7'd90;
  localparam logic [BrtW-1:0] ResetNominal = 7'd50;

  localparam logic [SegW-1:0] SegErr   = 7'h79;
  localparam logic [SegW-1:0] SegDash  = 7'h40;
  localparam logic [SegW-1:0] SegBlank = 7'h00;

  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChDash   = 8'h2D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [DvalW-1:0] DvalEnd  = 8'hFF;

  localparam logic [SegW-1:0] UpperTab [26] = '{
    7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h1E, 7'h75, 7'h38, 7'h15,
    7'h37, 7'h3F, 7'h73, 7'h6B, 7'h33, 7'h6D, 7'h78, 7'h3E, 7'h3E, 7'h2A, 7'h76, 7'h6E, 7'h5B};
  localparam logic [SegW-1:0] LowerTab [26] = '{
    7'h5F, 7'h7C, 7'h58, 7'h5E, 7'h7B, 7'h71, 7'h6F, 7'h74, 7'h10, 7'h0C, 7'h75, 7'h30, 7'h14,
    7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h1C, 7'h1C, 7'h14, 7'h76, 7'h6E, 7'h5B};
  localparam logic [SegW-1:0] NumTab [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  // stored entry: end marker flag plus segment lines
  typedef struct packed {
    logic            end_mark;
    logic [SegW-1:0] seg;
  } pat_t;

  typedef logic [BufLen-1:0] flag_vec_t;

  // window starting at start fits and its last digit is not the end marker
  function automatic logic win_ok(logic [BufAw:0] start, flag_vec_t end_vec);
    logic [BufAw:0] last;
    last = start + (BufAw+1)'(DigitCount - 1);
    if (start > (BufAw+1)'(WinSpan)) return 1'b0;
    return !end_vec[last[BufAw-1:0]];
  endfunction

endpackage

FILE: hdl/ssmd_if.sv
// ----------------------------------------------------------------------------
// ssmd_if
// Valid/ready channels for command beats and display result beats.
// ----------------------------------------------------------------------------
interface ssmd_in_if;
  import ssmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [PosW-1:0]  position;
  logic [CharW-1:0] char_code;
  logic [DvalW-1:0] digit_value;

  modport source (output valid, kind, position, char_code, digit_value, input ready);
  modport sink   (input valid, kind, position, char_code, digit_value, output ready);
endinterface

interface ssmd_out_if;
  import ssmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DigW-1:0]  active_digit;
  logic [SegW-1:0]  segments;
  logic [BufAw-1:0] window_start;
  logic             rotating;

  modport source (output valid, active_digit, segments, window_start, rotating, input ready);
  modport sink   (input valid, active_digit, segments, window_start, rotating, output ready);
endinterface

FILE: hdl/scrolling_seven_segment_mux_driver.sv
// ----------------------------------------------------------------------------
// scrolling_seven_segment_mux_driver
// Four-digit multiplexed seven-segment driver with a scrolling text window.
// ----------------------------------------------------------------------------
// Latency: a result beat is valid the cycle after its command beat is taken.
// Throughput: one command per cycle; the single output register holds one
// result and a new command is taken whenever that register is empty or empties that cycle.
// Reset (async, active low): empty buffer, brightness 50, window/scan/slot 0,
// rotation stopped, auto rotation enabled, no result pending.
`include "assert_macros.svh"

module scrolling_seven_segment_mux_driver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssmd_in_if.sink                       in_i,
  ssmd_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [ssmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ssmd_pkg::CfgDataW-1:0] cfg_data_i
);
  import ssmd_pkg::*;

  // buffer state: end flags reset to all set, patterns need no reset
  flag_vec_t       end_q, end_d;
  logic [SegW-1:0] seg_q [BufLen];
  logic [SegW-1:0] seg_d [BufLen];
  // brightness is base level unless the entry's high bit is set
  flag_vec_t       hi_q, hi_d;
  logic [BrtW-1:0] base_q, base_d;

  logic [BrtW-1:0]  nominal_q;
  logic             auto_rot_q;
  logic [BufAw-1:0] win_q, win_d;
  logic [DigW-1:0]  scan_q, scan_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             rot_q, rot_d;

  logic             out_valid_q;
  logic [DigW-1:0]  out_dig_q;
  logic [SegW-1:0]  out_seg_q, out_seg_d;
  logic [BufAw-1:0] out_win_q;
  logic             out_rot_q;

  pat_t             pat;
  logic             in_acc;
  logic             halt_kind;
  logic             pos_ok;
  logic [BufAw-1:0] win_base;
  logic [BufAw:0]   win_inc;
  logic [BufAw:0]   win_last;
  logic [BufAw:0]   idx;
  logic [BrtW-1:0]  brt;

  ssmd_encode u_encode (
    .kind_i        (in_i.kind),
    .char_code_i   (in_i.char_code),
    .digit_value_i (in_i.digit_value),
    .pat_o         (pat)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    end_d  = end_q;
    seg_d  = seg_q;
    hi_d   = hi_q;
    base_d = base_q;
    scan_d = scan_q;
    slot_d = slot_q;

    pos_ok = (BufAw+1)'(in_i.position) < (BufAw+1)'(BufLen);

    // writes, clear and scrolling stop an active rotation and home the window
    halt_kind = (in_i.kind == KIND_WR_CHAR) || (in_i.kind == KIND_WR_DIGIT) ||
                (in_i.kind == KIND_CLEAR) || (in_i.kind == KIND_LEFT) ||
                (in_i.kind == KIND_RIGHT);
    win_base  = (halt_kind && rot_q) ? '0 : win_q;
    rot_d     = halt_kind ? 1'b0 : rot_q;
    win_d     = win_base;
    win_inc   = (BufAw+1)'(win_base) + (BufAw+1)'(1);
    win_last  = (BufAw+1)'(win_base) + (BufAw+1)'(DigitCount - 1);

    case (in_i.kind)
      KIND_TICK: begin
        if (slot_q == SlotW'(SlotTicks - 1)) begin
          slot_d = '0;
          scan_d = (scan_q == DigW'(DigitCount - 1)) ? '0 : scan_q + 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      KIND_ROT_TICK: begin
        if (rot_q) begin
          win_d = win_ok(win_inc, end_q) ? win_inc[BufAw-1:0] : '0;
        end
      end
      KIND_WR_CHAR, KIND_WR_DIGIT: begin
        if (pos_ok) begin
          end_d[in_i.position] = pat.end_mark;
          seg_d[in_i.position] = pat.seg;
        end
      end
      KIND_CLEAR: begin
        base_d = nominal_q;
        hi_d   = '0;
        end_d  = '1;
      end
      KIND_START: begin
        if (auto_rot_q) rot_d = 1'b1;
      end
      KIND_LEFT: begin
        if (win_base != '0) win_d = win_base - 1'b1;
      end
      KIND_RIGHT: begin
        if ((BufAw+1)'(win_base) < (BufAw+1)'(WinSpan) && !end_q[win_last[BufAw-1:0]]) begin
          win_d = win_inc[BufAw-1:0];
        end
      end
      KIND_SET_WIN: begin
        if (win_ok((BufAw+1)'(in_i.position), end_q)) win_d = in_i.position;
      end
      KIND_HL_SOFT: begin
        if (pos_ok) hi_d[in_i.position] = 1'b1;
      end
      KIND_HL_HARD: begin
        base_d = LowDuty;
        hi_d   = '0;
        if (pos_ok) hi_d[in_i.position] = 1'b1;
      end
      KIND_HL_OFF: begin
        base_d = nominal_q;
        hi_d   = '0;
      end
      default: ;
    endcase

    // result reflects the state after this beat's update
    idx       = (BufAw+1)'(win_d) + (BufAw+1)'(scan_d);
    brt       = hi_d[idx[BufAw-1:0]] ? HighDuty : base_d;
    out_seg_d = '0;
    if (idx < (BufAw+1)'(BufLen) && !end_d[idx[BufAw-1:0]] && slot_d < brt) begin
      out_seg_d = seg_d[idx[BufAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q       <= '1;
      hi_q        <= '0;
      base_q      <= ResetNominal;
      nominal_q   <= ResetNominal;
      auto_rot_q  <= 1'b1;
      win_q       <= '0;
      scan_q      <= '0;
      slot_q      <= '0;
      rot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        end_q  <= end_d;
        hi_q   <= hi_d;
        base_q <= base_d;
        win_q  <= win_d;
        scan_q <= scan_d;
        slot_q <= slot_d;
        rot_q  <= rot_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NOMINAL: begin
            if (cfg_data_i >= MinNominal && cfg_data_i <= MaxNominal) begin
              nominal_q <= cfg_data_i;
              base_q    <= cfg_data_i;
              hi_q      <= '0;
            end
          end
          CFG_AUTO_ROT: auto_rot_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seg_q     <= seg_d;
      out_dig_q <= scan_d;
      out_seg_q <= out_seg_d;
      out_win_q <= win_d;
      out_rot_q <= rot_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.active_digit = out_dig_q;
  assign out_o.segments     = out_seg_q;
  assign out_o.window_start = out_win_q;
  assign out_o.rotating     = out_rot_q;

  // a right scroll that stops rotation may step the homed window once
  `ASSERT_NEXT(a_result_follows_beat, clk_i, rst_ni, in_acc, out_valid_q)
  `ASSERT_IMPL(a_window_in_span, clk_i, rst_ni, 1'b1, win_q <= BufAw'(WinSpan))
  `ASSERT_IMPL(a_stop_homes_window, clk_i, rst_ni, $fell(rot_q), win_q <= BufAw'(1))
  `ASSERT_IMPL(a_slot_in_range, clk_i, rst_ni, 1'b1, slot_q < SlotW'(SlotTicks))

endmodule

FILE: hdl/ssmd_encode.sv
// ----------------------------------------------------------------------------
// ssmd_encode
// Maps an ASCII code or a decimal digit to a stored segment pattern.
// ----------------------------------------------------------------------------
module ssmd_encode (
  input  logic [ssmd_pkg::KindW-1:0] kind_i,
  input  logic [ssmd_pkg::CharW-1:0] char_code_i,
  input  logic [ssmd_pkg::DvalW-1:0] digit_value_i,
  output ssmd_pkg::pat_t             pat_o
);
  import ssmd_pkg::*;

  pat_t             char_pat;
  pat_t             num_pat;
  logic [CharW-1:0] up_off;
  logic [CharW-1:0] lo_off;

  always_comb begin
    up_off = char_code_i - ChUpperA;
    lo_off = char_code_i - ChLowerA;
    if (char_code_i >= ChUpperA && char_code_i <= ChUpperZ) begin
      char_pat = '{end_mark: 1'b0, seg: UpperTab[up_off[4:0]]};
    end else if (char_code_i >= ChLowerA && char_code_i <= ChLowerZ) begin
      char_pat = '{end_mark: 1'b0, seg: LowerTab[lo_off[4:0]]};
    end else if (char_code_i == ChDash) begin
      char_pat = '{end_mark: 1'b0, seg: SegDash};
    end else if (char_code_i == ChSpace) begin
      char_pat = '{end_mark: 1'b0, seg: SegBlank};
    end else if (char_code_i == ChNul) begin
      char_pat = '{end_mark: 1'b1, seg: SegBlank};
    end else begin
      char_pat = '{end_mark: 1'b0, seg: SegErr};
    end

    if (digit_value_i < DvalW'(10)) begin
      num_pat = '{end_mark: 1'b0, seg: NumTab[digit_value_i[3:0]]};
    end else if (digit_value_i == DvalEnd) begin
      num_pat = '{end_mark: 1'b1, seg: SegBlank};
    end else begin
      num_pat = '{end_mark: 1'b0, seg: SegErr};
    end

    pat_o = (kind_i == KIND_WR_DIGIT) ? num_pat : char_pat;
  end

endmodule

FILE: bench/scrolling_seven_segment_mux_driver_tb.sv
// ----------------------------------------------------------------------------
// scrolling_seven_segment_mux_driver_tb
// Self-checking bench for the scrolling seven-segment driver. Command beats
// come from a queue, a copy of the display state predicts
// every result beat, and the monitor checks each one field by field. Sender
// and receiver idle at random, and the receiver also holds off for a while.
// ----------------------------------------------------------------------------
module scrolling_seven_segment_mux_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssmd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 60;
  localparam logic [7:0] EndMark = 8'hFF;
  localparam logic [KindW-1:0] KIND_SPARE_LO = 4'd12;
  localparam logic [KindW-1:0] KIND_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  pos;
    logic [CharW-1:0] ch;
    logic [DvalW-1:0] dval;
  } disp_cmd_t;

  typedef struct packed {
    logic [DigW-1:0]  digit;
    logic [SegW-1:0]  seg;
    logic [BufAw-1:0] win;
    logic             rot;
  } disp_frame_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  ssmd_in_if  cmd_if ();
  ssmd_out_if disp_if ();

  scrolling_seven_segment_mux_driver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if),
    .out_o      (disp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // display state mirror
  logic [7:0]       seg_buf [BufLen];
  logic [BrtW-1:0]  duty [BufLen];
  logic [BufAw-1:0] win_idx;
  logic [DigW-1:0]  scan;
  logic [SlotW-1:0] slot;
  logic             rot_on;
  logic [BrtW-1:0]  nominal;
  logic             auto_rot;

  disp_cmd_t   cmd_queue[$];
  disp_frame_t expected_frames[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  mismatches;
  int  cycle_count;
  int  hold_left;
  bit  hold_req;
  bit  cmd_taken;

  function automatic void fill_duty(input logic [BrtW-1:0] level);
    for (int i = 0; i < BufLen; i++) duty[i] = level;
  endfunction

  function automatic void stop_rotation();
    if (rot_on) begin
      rot_on  = 1'b0;
      win_idx = '0;
    end
  endfunction

  function automatic bit window_fits(input int start);
    if (start > WinSpan) return 1'b0;
    return seg_buf[start + DigitCount - 1] != EndMark;
  endfunction

  // apply one command to the mirror and return the frame it shows
  function automatic disp_frame_t advance_display(input disp_cmd_t c);
    disp_frame_t f;
    logic [7:0]  pat;
    int          w;
    int          idx;
    pat = EndMark;
    case (c.kind)
      KIND_TICK: begin
        if (int'(slot) + 1 >= SlotTicks) begin
          slot = '0;
          scan = (int'(scan) + 1 >= DigitCount) ? '0 : scan + 1'b1;
        end else begin
          slot = slot + 1'b1;
        end
      end
      KIND_ROT_TICK: begin
        if (rot_on) begin
          w = int'(win_idx) + 1;
          if (!window_fits(w)) w = 0;
          win_idx = w[BufAw-1:0];
        end
      end
      KIND_WR_CHAR: begin
        if (c.ch >= ChUpperA && c.ch <= ChUpperZ) pat = {1'b0, UpperTab[c.ch - ChUpperA]};
        else if (c.ch >= ChLowerA && c.ch <= ChLowerZ) pat = {1'b0, LowerTab[c.ch - ChLowerA]};
        else if (c.ch == ChDash) pat = {1'b0, SegDash};
        else if (c.ch == ChSpace) pat = {1'b0, SegBlank};
        else if (c.ch == ChNul) pat = EndMark;
        else pat = {1'b0, SegErr};
        stop_rotation();
        seg_buf[c.pos] = pat;
      end
      KIND_WR_DIGIT: begin
        if (c.dval < 10) pat = {1'b0, NumTab[c.dval]};
        else if (c.dval == DvalEnd) pat = EndMark;
        else pat = {1'b0, SegErr};
        stop_rotation();
        seg_buf[c.pos] = pat;
      end
      KIND_CLEAR: begin
        fill_duty(nominal);
        stop_rotation();
        for (int i = 0; i < BufLen; i++) seg_buf[i] = EndMark;
      end
      KIND_START: begin
        if (auto_rot) rot_on = 1'b1;
      end
      KIND_LEFT: begin
        stop_rotation();
        if (win_idx != 0) win_idx = win_idx - 1'b1;
      end
      KIND_RIGHT: begin
        stop_rotation();
        if (int'(win_idx) < WinSpan && seg_buf[int'(win_idx) + DigitCount - 1] != EndMark)
          win_idx = win_idx + 1'b1;
      end
      KIND_SET_WIN: begin
        if (window_fits(int'(c.pos))) win_idx = c.pos;
      end
      KIND_HL_SOFT: duty[c.pos] = HighDuty;
      KIND_HL_HARD: begin
        fill_duty(LowDuty);
        duty[c.pos] = HighDuty;
      end
      KIND_HL_OFF: fill_duty(nominal);
      default: ;
    endcase
    idx     = int'(win_idx) + int'(scan);
    f.digit = scan;
    f.win   = win_idx;
    f.rot   = rot_on;
    f.seg   = '0;
    if (idx < BufLen && seg_buf[idx] != EndMark && slot < duty[idx])
      f.seg = seg_buf[idx][SegW-1:0];
    return f;
  endfunction

  function automatic void push_cmd(input logic [KindW-1:0] kind, input logic [PosW-1:0] pos,
                                   input logic [CharW-1:0] ch, input logic [DvalW-1:0] dval);
    disp_cmd_t c;
    c.kind = kind;
    c.pos  = pos;
    c.ch   = ch;
    c.dval = dval;
    cmd_queue.push_back(c);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL scrolling_seven_segment_mux_driver");
      $finish;
    end
  end

  // monitor: check output beats first, then predict the command beat taken
  always @(posedge clk_i) begin
    disp_frame_t want;
    disp_cmd_t   c;
    if (rst_ni) begin
      if (disp_if.valid && disp_if.ready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual digit %0d seg 0x%0h",
                   $time, disp_if.active_digit, disp_if.segments);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          check_field("active_digit", int'(want.digit), int'(disp_if.active_digit));
          check_field("segments", int'(want.seg), int'(disp_if.segments));
          check_field("window_start", int'(want.win), int'(disp_if.window_start));
          check_field("rotating", int'(want.rot), int'(disp_if.rotating));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        c.kind = cmd_if.kind;
        c.pos  = cmd_if.position;
        c.ch   = cmd_if.char_code;
        c.dval = cmd_if.digit_value;
        expected_frames.push_back(advance_display(c));
        cmd_taken = 1'b1;
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    disp_cmd_t c;
    if (rst_ni && (!cmd_if.valid || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = cmd_queue.pop_front();
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= c.kind;
        cmd_if.position    <= c.pos;
        cmd_if.char_code   <= c.ch;
        cmd_if.digit_value <= c.dval;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random idling and a counted hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        disp_if.ready <= 1'b0;
      end else begin
        disp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == CFG_NOMINAL) begin
      if (data >= MinNominal && data <= MaxNominal) begin
        nominal = data;
        fill_duty(data);
      end
    end else begin
      auto_rot = data[0];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || cmd_if.valid || expected_frames.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // random traffic: text runs, tick bursts, rotation runs and raw noise
  task automatic queue_random_stimulus(input int count);
    int produced;
    int sel;
    int len;
    int start;
    int r;
    logic [7:0] ch;
    logic [7:0] dv;
    produced = 0;
    while (produced < count) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        len   = $urandom_range(8, 1);
        start = $urandom_range(BufLen - 1);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(9);
          if (r < 4) ch = ChUpperA + 8'($urandom_range(25));
          else if (r < 7) ch = ChLowerA + 8'($urandom_range(25));
          else if (r == 7) ch = $urandom_range(1) ? ChDash : ChSpace;
          else if (r == 8) ch = ChNul;
          else ch = 8'($urandom_range(255));
          r  = $urandom_range(9);
          dv = (r < 8) ? 8'($urandom_range(9)) : (r == 8 ? DvalEnd : 8'($urandom_range(255)));
          push_cmd($urandom_range(9) < 7 ? KIND_WR_CHAR : KIND_WR_DIGIT,
                   PosW'((start + i) % BufLen), ch, dv);
        end
        produced += len;
        if ($urandom_range(1)) begin
          push_cmd($urandom_range(1) ? KIND_RIGHT : KIND_SET_WIN, PosW'($urandom_range(15)),
                   CharW'($urandom_range(255)), DvalW'($urandom_range(255)));
          produced++;
        end
      end else if (sel < 75) begin
        len = $urandom_range(30, 5);
        for (int i = 0; i < len; i++)
          push_cmd(KIND_TICK, PosW'($urandom_range(15)), CharW'($urandom_range(255)),
                   DvalW'($urandom_range(255)));
        produced += len;
      end else if (sel < 85) begin
        len = $urandom_range(8, 2);
        push_cmd(KIND_START, PosW'($urandom_range(15)), CharW'($urandom_range(255)),
                 DvalW'($urandom_range(255)));
        for (int i = 0; i < len; i++)
          push_cmd($urandom_range(3) != 0 ? KIND_ROT_TICK : KIND_TICK,
                   PosW'($urandom_range(15)), CharW'($urandom_range(255)),
                   DvalW'($urandom_range(255)));
        produced += len + 1;
      end else begin
        push_cmd(KindW'($urandom_range(15)), PosW'($urandom_range(15)),
                 CharW'($urandom_range(255)), DvalW'($urandom_range(255)));
        produced++;
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.kind        = '0;
    cmd_if.position    = '0;
    cmd_if.char_code   = '0;
    cmd_if.digit_value = '0;
    disp_if.ready      = 1'b0;
    send_idle_pct      = 14;
    recv_idle_pct      = 58;
    mismatches         = 0;
    cycle_count        = 0;
    hold_left          = 0;
    hold_req           = 1'b0;
    cmd_taken          = 1'b0;
    for (int i = 0; i < BufLen; i++) seg_buf[i] = EndMark;
    fill_duty(ResetNominal);
    win_idx  = '0;
    scan     = '0;
    slot     = '0;
    rot_on   = 1'b0;
    nominal  = ResetNominal;
    auto_rot = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // empty buffer: ignored rotate tick, refused window, right at end, left at zero
    push_cmd(KIND_ROT_TICK, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_SET_WIN, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_RIGHT, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_LEFT, 4'd0, 8'h00, 8'h00);
    // character and digit table corners and unknown codes
    push_cmd(KIND_WR_CHAR, 4'd0, ChUpperA, 8'h00);
    push_cmd(KIND_WR_CHAR, 4'd1, ChLowerZ, 8'h00);
    push_cmd(KIND_WR_CHAR, 4'd2, ChDash, 8'h00);
    push_cmd(KIND_WR_CHAR, 4'd3, ChSpace, 8'h00);
    push_cmd(KIND_WR_CHAR, 4'd4, 8'hFF, 8'h00);
    push_cmd(KIND_WR_DIGIT, 4'd5, 8'h00, 8'd0);
    push_cmd(KIND_WR_DIGIT, 4'd6, 8'h00, 8'd9);
    push_cmd(KIND_WR_DIGIT, 4'd7, 8'h00, 8'd10);
    push_cmd(KIND_WR_DIGIT, 4'd15, 8'h00, 8'd9);
    // last window accepted, one past it refused
    push_cmd(KIND_SET_WIN, 4'd12, 8'h00, 8'h00);
    push_cmd(KIND_SET_WIN, 4'd13, 8'h00, 8'h00);
    push_cmd(KIND_WR_CHAR, 4'd4, ChNul, 8'h00);
    push_cmd(KIND_SET_WIN, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_RIGHT, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_HL_SOFT, 4'd15, 8'h00, 8'h00);
    push_cmd(KIND_HL_HARD, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_HL_OFF, 4'd0, 8'h00, 8'h00);
    // rotation advances the window
    push_cmd(KIND_START, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_ROT_TICK, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_ROT_TICK, 4'd0, 8'h00, 8'h00);
    wait_drained();

    // auto rotation off while rotating; out-of-range brightness ignored
    write_register(CFG_AUTO_ROT, 7'h00);
    write_register(CFG_NOMINAL, 7'd9);
    write_register(CFG_NOMINAL, 7'd91);
    push_cmd(KIND_ROT_TICK, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_WR_DIGIT, 4'd14, 8'h00, DvalEnd);
    push_cmd(KIND_START, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_SPARE_HI, 4'hF, 8'hFF, 8'hFF);
    push_cmd(KIND_SPARE_LO, 4'd0, 8'h00, 8'h00);
    push_cmd(KIND_CLEAR, 4'd0, 8'h00, 8'h00);
    wait_drained();

    write_register(CFG_NOMINAL, 7'd0);
    write_register(CFG_NOMINAL, 7'h7F);
    write_register(CFG_NOMINAL, MinNominal);
    write_register(CFG_AUTO_ROT, 7'h7F);
    queue_random_stimulus(120);
    wait_drained();

    send_idle_pct = 58;
    recv_idle_pct = 14;
    write_register(CFG_NOMINAL, MaxNominal);
    write_register(CFG_AUTO_ROT, 7'h7E);
    queue_random_stimulus(120);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(CFG_NOMINAL, 7'($urandom_range(90, 10)));
    write_register(CFG_AUTO_ROT, 7'h01);
    queue_random_stimulus(120);
    hold_req = 1'b1;
    wait_drained();
    repeat (5) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("PASS scrolling_seven_segment_mux_driver");
    end else begin
      $display("FAIL scrolling_seven_segment_mux_driver");
    end
    $finish;
  end

endmodule
